// ===== rtl/core/pldf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pldf_pkg
// Shared types and constants of the point-to-line distance filter.
// ----------------------------------------------------------------------------
package pldf_pkg;

   localparam int DEFAULT_COORD_WIDTH = 24;
   localparam int NUM_AXES            = 3;

   // direction components are Q2.14
   localparam int DIR_WIDTH = 16;
   localparam int DIR_FRAC  = 14;

   localparam int MAXD_WIDTH = 23;

   // one half in the Q.14 fraction, used for round-to-nearest
   localparam logic [DIR_FRAC-1:0] ROUND_HALF = DIR_FRAC'(1) << (DIR_FRAC - 1);

   localparam logic signed [DIR_WIDTH-1:0] DIRECTION_ONE = DIR_WIDTH'(16384);

   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ANCHOR_X     = 3'd0,
      CSR_ANCHOR_Y     = 3'd1,
      CSR_ANCHOR_Z     = 3'd2,
      CSR_DIRECTION_X  = 3'd3,
      CSR_DIRECTION_Y  = 3'd4,
      CSR_DIRECTION_Z  = 3'd5,
      CSR_MAX_DISTANCE = 3'd6
   } csr_index_type;

endpackage
`default_nettype wire

// ===== rtl/core/point_line_distance_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// point_line_distance_filter
// Flags 3D points that lie within a set distance of a configured line.
// ----------------------------------------------------------------------------
// Usage:
//   Points enter on the req_ channel (valid/stall) and leave on the rsp_
//   channel with rsp_is_close and the point unchanged, one result per point,
//   in order. The line (anchor, direction) and max_distance are written on
//   the csr_ port, one register per cycle; the user must write them only
//   while no point is in flight, which the block itself does not enforce.
//   Throughput is one point per cycle while rsp_stall is low, set by the
//   8-stage pipeline (3 projection, 3 residual, 2 compare stages).
//   When rsp_stall is high, stages fill up behind the output register;
//   req_stall rises only once all 8 stages hold a point. Nothing is lost or
//   repeated across a stall.
//   Reset (synchronous) empties the pipeline and restores the registers:
//   anchor at the origin, direction along +x, max_distance zero.
// ----------------------------------------------------------------------------
module point_line_distance_filter #(
   parameter int COORD_WIDTH = pldf_pkg::DEFAULT_COORD_WIDTH,
   localparam int CSR_WIDTH = (COORD_WIDTH > pldf_pkg::MAXD_WIDTH) ?
                              COORD_WIDTH : pldf_pkg::MAXD_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_WIDTH-1:0]          req_point_x,
   input  logic signed [COORD_WIDTH-1:0]          req_point_y,
   input  logic signed [COORD_WIDTH-1:0]          req_point_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_is_close,
   output logic signed [COORD_WIDTH-1:0]          rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]          rsp_out_y,
   output logic signed [COORD_WIDTH-1:0]          rsp_out_z,
   input  logic                                   csr_write,
   input  logic [pldf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [CSR_WIDTH-1:0]                   csr_wdata
);

   localparam int VW = COORD_WIDTH + 1;
   localparam int TW = COORD_WIDTH + 19 - pldf_pkg::DIR_FRAC;
   localparam int MW = COORD_WIDTH + 8;

   logic signed [COORD_WIDTH-1:0]         anchor_ff    [pldf_pkg::NUM_AXES];
   logic signed [pldf_pkg::DIR_WIDTH-1:0] direction_ff [pldf_pkg::NUM_AXES];
   logic [pldf_pkg::MAXD_WIDTH-1:0]       max_distance_ff;

   logic signed [COORD_WIDTH-1:0] req_point [pldf_pkg::NUM_AXES];

   logic                          proj_valid, proj_stall;
   logic signed [VW-1:0]          proj_v     [pldf_pkg::NUM_AXES];
   logic signed [TW-1:0]          proj_t;
   logic signed [COORD_WIDTH-1:0] proj_point [pldf_pkg::NUM_AXES];

   logic                          res_valid, res_stall;
   logic        [MW-1:0]          res_mag    [pldf_pkg::NUM_AXES];
   logic signed [COORD_WIDTH-1:0] res_point  [pldf_pkg::NUM_AXES];

   logic signed [COORD_WIDTH-1:0] rsp_point  [pldf_pkg::NUM_AXES];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_ff[0]    <= '0;
         anchor_ff[1]    <= '0;
         anchor_ff[2]    <= '0;
         direction_ff[0] <= pldf_pkg::DIRECTION_ONE;
         direction_ff[1] <= '0;
         direction_ff[2] <= '0;
         max_distance_ff <= '0;
      end else if (csr_write) begin
         case (pldf_pkg::csr_index_type'(csr_index))
            pldf_pkg::CSR_ANCHOR_X: begin
               anchor_ff[0] <= csr_wdata[COORD_WIDTH-1:0];
            end
            pldf_pkg::CSR_ANCHOR_Y: begin
               anchor_ff[1] <= csr_wdata[COORD_WIDTH-1:0];
            end
            pldf_pkg::CSR_ANCHOR_Z: begin
               anchor_ff[2] <= csr_wdata[COORD_WIDTH-1:0];
            end
            pldf_pkg::CSR_DIRECTION_X: begin
               direction_ff[0] <= csr_wdata[pldf_pkg::DIR_WIDTH-1:0];
            end
            pldf_pkg::CSR_DIRECTION_Y: begin
               direction_ff[1] <= csr_wdata[pldf_pkg::DIR_WIDTH-1:0];
            end
            pldf_pkg::CSR_DIRECTION_Z: begin
               direction_ff[2] <= csr_wdata[pldf_pkg::DIR_WIDTH-1:0];
            end
            pldf_pkg::CSR_MAX_DISTANCE: begin
               max_distance_ff <= csr_wdata[pldf_pkg::MAXD_WIDTH-1:0];
            end
            default: begin
               // unknown index: write dropped
            end
         endcase
      end
   end

   assign req_point[0] = req_point_x;
   assign req_point[1] = req_point_y;
   assign req_point[2] = req_point_z;

   pldf_project #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_project (
      .clock     (clock),
      .reset     (reset),
      .anchor    (anchor_ff),
      .direction (direction_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_point  (req_point),
      .out_valid (proj_valid),
      .out_stall (proj_stall),
      .out_v     (proj_v),
      .out_t     (proj_t),
      .out_point (proj_point)
   );

   pldf_residual #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_residual (
      .clock     (clock),
      .reset     (reset),
      .direction (direction_ff),
      .in_valid  (proj_valid),
      .in_stall  (proj_stall),
      .in_v      (proj_v),
      .in_t      (proj_t),
      .in_point  (proj_point),
      .out_valid (res_valid),
      .out_stall (res_stall),
      .out_mag   (res_mag),
      .out_point (res_point)
   );

   pldf_compare #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_compare (
      .clock        (clock),
      .reset        (reset),
      .max_distance (max_distance_ff),
      .in_valid     (res_valid),
      .in_stall     (res_stall),
      .in_mag       (res_mag),
      .in_point     (res_point),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_close    (rsp_is_close),
      .out_point    (rsp_point)
   );

   assign rsp_out_x = rsp_point[0];
   assign rsp_out_y = rsp_point[1];
   assign rsp_out_z = rsp_point[2];

   // input backs up only when the whole pipeline is blocked at the output
   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output could move");

   // reset leaves no result behind
   a_reset_empties : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
`default_nettype wire

// ===== rtl/core/pldf_project.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pldf_project
// Three stages: offset from the anchor, per-axis products with the direction,
// then the dot product rounded to coordinate format (projection length t).
// ----------------------------------------------------------------------------
module pldf_project #(
   parameter int COORD_WIDTH = pldf_pkg::DEFAULT_COORD_WIDTH,
   localparam int VW   = COORD_WIDTH + 1,
   localparam int TW   = COORD_WIDTH + 19 - pldf_pkg::DIR_FRAC
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [COORD_WIDTH-1:0]         anchor    [pldf_pkg::NUM_AXES],
   input  logic signed [pldf_pkg::DIR_WIDTH-1:0] direction [pldf_pkg::NUM_AXES],
   input  logic                                  in_valid,
   output logic                                  in_stall,
   input  logic signed [COORD_WIDTH-1:0]         in_point  [pldf_pkg::NUM_AXES],
   output logic                                  out_valid,
   input  logic                                  out_stall,
   output logic signed [VW-1:0]                  out_v     [pldf_pkg::NUM_AXES],
   output logic signed [TW-1:0]                  out_t,
   output logic signed [COORD_WIDTH-1:0]         out_point [pldf_pkg::NUM_AXES]
);

   localparam int PW   = VW + pldf_pkg::DIR_WIDTH;
   localparam int DOTW = PW + 2;

   logic valid1_ff, valid2_ff, valid3_ff;
   logic ready1, ready2, ready3;

   logic signed [VW-1:0]          v1_ff    [pldf_pkg::NUM_AXES];
   logic signed [VW-1:0]          v2_ff    [pldf_pkg::NUM_AXES];
   logic signed [VW-1:0]          v3_ff    [pldf_pkg::NUM_AXES];
   logic signed [PW-1:0]          prod2_ff [pldf_pkg::NUM_AXES];
   logic signed [COORD_WIDTH-1:0] p1_ff    [pldf_pkg::NUM_AXES];
   logic signed [COORD_WIDTH-1:0] p2_ff    [pldf_pkg::NUM_AXES];
   logic signed [COORD_WIDTH-1:0] p3_ff    [pldf_pkg::NUM_AXES];
   logic signed [DOTW-1:0]        dot_in;
   logic signed [TW-1:0]          t3_ff;

   // a stage takes new data when it is empty or its content moves on
   assign ready3   = !valid3_ff || !out_stall;
   assign ready2   = !valid2_ff || ready3;
   assign ready1   = !valid1_ff || ready2;
   assign in_stall = !ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (ready1) valid1_ff <= in_valid;
         if (ready2) valid2_ff <= valid1_ff;
         if (ready3) valid3_ff <= valid2_ff;
      end
   end

   for (genvar i = 0; i < pldf_pkg::NUM_AXES; i++) begin : g_lane
      always_ff @(posedge clock) begin
         if (ready1) begin
            v1_ff[i] <= VW'(in_point[i]) - VW'(anchor[i]);
            p1_ff[i] <= in_point[i];
         end
         if (ready2) begin
            prod2_ff[i] <= PW'(v1_ff[i] * direction[i]);
            v2_ff[i]    <= v1_ff[i];
            p2_ff[i]    <= p1_ff[i];
         end
         if (ready3) begin
            v3_ff[i] <= v2_ff[i];
            p3_ff[i] <= p2_ff[i];
         end
      end
      assign out_v[i]     = v3_ff[i];
      assign out_point[i] = p3_ff[i];
   end

   // dot product plus one half; dropping the fraction rounds to nearest
   assign dot_in = DOTW'(prod2_ff[0]) + DOTW'(prod2_ff[1]) + DOTW'(prod2_ff[2])
                   + DOTW'(pldf_pkg::ROUND_HALF);

   always_ff @(posedge clock) begin
      if (ready3) t3_ff <= dot_in[DOTW-1:pldf_pkg::DIR_FRAC];
   end

   assign out_t     = t3_ff;
   assign out_valid = valid3_ff;

endmodule
`default_nettype wire

// ===== rtl/core/pldf_residual.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pldf_residual
// Three stages: t times direction, perpendicular residual rounded to
// coordinate format, then its magnitude per axis.
// ----------------------------------------------------------------------------
module pldf_residual #(
   parameter int COORD_WIDTH = pldf_pkg::DEFAULT_COORD_WIDTH,
   localparam int VW = COORD_WIDTH + 1,
   localparam int TW = COORD_WIDTH + 19 - pldf_pkg::DIR_FRAC,
   localparam int MW = COORD_WIDTH + 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [pldf_pkg::DIR_WIDTH-1:0] direction [pldf_pkg::NUM_AXES],
   input  logic                                  in_valid,
   output logic                                  in_stall,
   input  logic signed [VW-1:0]                  in_v      [pldf_pkg::NUM_AXES],
   input  logic signed [TW-1:0]                  in_t,
   input  logic signed [COORD_WIDTH-1:0]         in_point  [pldf_pkg::NUM_AXES],
   output logic                                  out_valid,
   input  logic                                  out_stall,
   output logic        [MW-1:0]                  out_mag   [pldf_pkg::NUM_AXES],
   output logic signed [COORD_WIDTH-1:0]         out_point [pldf_pkg::NUM_AXES]
);

   localparam int TPW = TW + pldf_pkg::DIR_WIDTH;
   localparam int RW  = TPW + 1;

   logic valid1_ff, valid2_ff, valid3_ff;
   logic ready1, ready2, ready3;

   logic signed [TPW-1:0]         tp1_ff  [pldf_pkg::NUM_AXES];
   logic signed [VW-1:0]          v1_ff   [pldf_pkg::NUM_AXES];
   logic signed [RW-1:0]          r_in    [pldf_pkg::NUM_AXES];
   logic signed [MW-1:0]          e2_ff   [pldf_pkg::NUM_AXES];
   logic        [MW-1:0]          mag3_ff [pldf_pkg::NUM_AXES];
   logic signed [COORD_WIDTH-1:0] p1_ff   [pldf_pkg::NUM_AXES];
   logic signed [COORD_WIDTH-1:0] p2_ff   [pldf_pkg::NUM_AXES];
   logic signed [COORD_WIDTH-1:0] p3_ff   [pldf_pkg::NUM_AXES];

   assign ready3   = !valid3_ff || !out_stall;
   assign ready2   = !valid2_ff || ready3;
   assign ready1   = !valid1_ff || ready2;
   assign in_stall = !ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (ready1) valid1_ff <= in_valid;
         if (ready2) valid2_ff <= valid1_ff;
         if (ready3) valid3_ff <= valid2_ff;
      end
   end

   for (genvar i = 0; i < pldf_pkg::NUM_AXES; i++) begin : g_lane
      // v * 2^14 with the rounding half placed in the empty fraction bits
      assign r_in[i] = RW'($signed({v1_ff[i], pldf_pkg::ROUND_HALF})) - RW'(tp1_ff[i]);

      always_ff @(posedge clock) begin
         if (ready1) begin
            tp1_ff[i] <= TPW'(in_t * direction[i]);
            v1_ff[i]  <= in_v[i];
            p1_ff[i]  <= in_point[i];
         end
         if (ready2) begin
            e2_ff[i] <= r_in[i][RW-1:pldf_pkg::DIR_FRAC];
            p2_ff[i] <= p1_ff[i];
         end
         if (ready3) begin
            mag3_ff[i] <= e2_ff[i][MW-1] ? MW'(-e2_ff[i]) : MW'(e2_ff[i]);
            p3_ff[i]   <= p2_ff[i];
         end
      end
      assign out_mag[i]   = mag3_ff[i];
      assign out_point[i] = p3_ff[i];
   end

   assign out_valid = valid3_ff;

endmodule
`default_nettype wire

// ===== rtl/core/pldf_compare.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pldf_compare
// Two stages: per-axis limit check and squares, then the sum of squares
// against the squared limit.
// ----------------------------------------------------------------------------
module pldf_compare #(
   parameter int COORD_WIDTH = pldf_pkg::DEFAULT_COORD_WIDTH,
   localparam int MW = COORD_WIDTH + 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [pldf_pkg::MAXD_WIDTH-1:0]      max_distance,
   input  logic                                 in_valid,
   output logic                                 in_stall,
   input  logic        [MW-1:0]                 in_mag    [pldf_pkg::NUM_AXES],
   input  logic signed [COORD_WIDTH-1:0]        in_point  [pldf_pkg::NUM_AXES],
   output logic                                 out_valid,
   input  logic                                 out_stall,
   output logic                                 out_close,
   output logic signed [COORD_WIDTH-1:0]        out_point [pldf_pkg::NUM_AXES]
);

   localparam int CW   = (MW > pldf_pkg::MAXD_WIDTH) ? MW : pldf_pkg::MAXD_WIDTH;
   localparam int SQW  = 2 * pldf_pkg::MAXD_WIDTH;
   localparam int SUMW = SQW + 2;

   logic valid1_ff, valid2_ff;
   logic ready1, ready2;

   logic [CW-1:0]                 mag_ext [pldf_pkg::NUM_AXES];
   logic [pldf_pkg::NUM_AXES-1:0] over_in;
   logic                          over1_ff;
   logic [SQW-1:0]                sq1_ff  [pldf_pkg::NUM_AXES];
   logic [SQW-1:0]                maxd_sq_ff;
   logic [SUMW-1:0]               sum_in;
   logic                          close_in;
   logic                          close2_ff;
   logic signed [COORD_WIDTH-1:0] p1_ff   [pldf_pkg::NUM_AXES];
   logic signed [COORD_WIDTH-1:0] p2_ff   [pldf_pkg::NUM_AXES];

   assign ready2   = !valid2_ff || !out_stall;
   assign ready1   = !valid1_ff || ready2;
   assign in_stall = !ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (ready1) valid1_ff <= in_valid;
         if (ready2) valid2_ff <= valid1_ff;
      end
   end

   // the user changes limit only while idle, unenforced; square follows next cycle
   always_ff @(posedge clock) begin
      maxd_sq_ff <= SQW'(max_distance * max_distance);
   end

   for (genvar i = 0; i < pldf_pkg::NUM_AXES; i++) begin : g_lane
      assign mag_ext[i] = CW'(in_mag[i]);
      assign over_in[i] = mag_ext[i] > CW'(max_distance);

      // square only matters when the axis is within the limit
      always_ff @(posedge clock) begin
         if (ready1) begin
            sq1_ff[i] <= SQW'(mag_ext[i][pldf_pkg::MAXD_WIDTH-1:0]
                              * mag_ext[i][pldf_pkg::MAXD_WIDTH-1:0]);
            p1_ff[i]  <= in_point[i];
         end
         if (ready2) p2_ff[i] <= p1_ff[i];
      end
      assign out_point[i] = p2_ff[i];
   end

   assign sum_in   = SUMW'(sq1_ff[0]) + SUMW'(sq1_ff[1]) + SUMW'(sq1_ff[2]);
   assign close_in = !over1_ff && (sum_in <= SUMW'(maxd_sq_ff));

   always_ff @(posedge clock) begin
      if (ready1) over1_ff  <= |over_in;
      if (ready2) close2_ff <= close_in;
   end

   assign out_valid = valid2_ff;
   assign out_close = close2_ff;

   // an axis within the limit cannot square beyond the squared limit
   a_square_bound : assert property (@(posedge clock) disable iff (reset)
      valid1_ff && !over1_ff |-> (sq1_ff[0] <= maxd_sq_ff) && (sq1_ff[1] <= maxd_sq_ff)
                                 && (sq1_ff[2] <= maxd_sq_ff))
      else $error("square above squared limit on an in-range axis");

endmodule
`default_nettype wire

// ===== tb/sv/pldf_distance_checker.sv =====
// ----------------------------------------------------------------------------
// pldf_distance_checker
// Scoreboard for the point-to-line distance filter.
// Tracks the line registers from the csr_ port, computes the expected keep
// flag of every point transferred on req_, and compares each rsp_ transfer,
// field by field, with the oldest pending verdict.
// ----------------------------------------------------------------------------
module pldf_distance_checker #(
   parameter int COORD_WIDTH = pldf_pkg::DEFAULT_COORD_WIDTH,
   parameter int CSR_WIDTH   = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic signed [COORD_WIDTH-1:0]          req_point_x,
   input  logic signed [COORD_WIDTH-1:0]          req_point_y,
   input  logic signed [COORD_WIDTH-1:0]          req_point_z,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic                                   rsp_is_close,
   input  logic signed [COORD_WIDTH-1:0]          rsp_out_x,
   input  logic signed [COORD_WIDTH-1:0]          rsp_out_y,
   input  logic signed [COORD_WIDTH-1:0]          rsp_out_z,
   input  logic                                   csr_write,
   input  logic [pldf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [CSR_WIDTH-1:0]                   csr_wdata,
   output int                                     mismatch_count,
   output int                                     points_in_flight
);

   typedef struct packed {
      logic                          is_close;
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } point_verdict_type;

   localparam int REPORT_LIMIT = 10;

   logic signed [COORD_WIDTH-1:0]         anchor_x, anchor_y, anchor_z;
   logic signed [pldf_pkg::DIR_WIDTH-1:0] dir_x, dir_y, dir_z;
   logic [pldf_pkg::MAXD_WIDTH-1:0]       max_dist;

   point_verdict_type pending_verdicts[$];
   point_verdict_type oldest;
   point_verdict_type incoming;
   int                results_seen;

   initial begin
      mismatch_count   = 0;
      points_in_flight = 0;
      results_seen     = 0;
   end

   // round a Q.(F+14) value to Q.F, ties toward plus infinity
   function automatic longint round_q14(input longint y);
      return (y + (longint'(1) <<< (pldf_pkg::DIR_FRAC - 1))) >>> pldf_pkg::DIR_FRAC;
   endfunction

   function automatic logic point_near_line(input logic signed [COORD_WIDTH-1:0] px,
                                            input logic signed [COORD_WIDTH-1:0] py,
                                            input logic signed [COORD_WIDTH-1:0] pz);
      longint v [3];
      longint d [3];
      longint dot, t, r, e, sum, lim;
      logic   close;
      v[0]  = longint'(px) - longint'(anchor_x);
      v[1]  = longint'(py) - longint'(anchor_y);
      v[2]  = longint'(pz) - longint'(anchor_z);
      d[0]  = longint'(dir_x);
      d[1]  = longint'(dir_y);
      d[2]  = longint'(dir_z);
      dot   = v[0] * d[0] + v[1] * d[1] + v[2] * d[2];
      t     = round_q14(dot);
      lim   = longint'(max_dist);
      sum   = 0;
      close = 1'b1;
      for (int i = 0; i < 3; i++) begin
         r = (v[i] <<< pldf_pkg::DIR_FRAC) - t * d[i];
         e = round_q14(r);
         if (e < 0)
            e = -e;
         // a single axis past the limit already decides it, keeps sum small
         if (e > lim)
            close = 1'b0;
         else
            sum += e * e;
      end
      if (close && sum > lim * lim)
         close = 1'b0;
      return close;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (want !== got)
         note_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         anchor_x = '0;
         anchor_y = '0;
         anchor_z = '0;
         dir_x    = pldf_pkg::DIRECTION_ONE;
         dir_y    = '0;
         dir_z    = '0;
         max_dist = '0;
         pending_verdicts.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               pldf_pkg::CSR_ANCHOR_X:     anchor_x = csr_wdata[COORD_WIDTH-1:0];
               pldf_pkg::CSR_ANCHOR_Y:     anchor_y = csr_wdata[COORD_WIDTH-1:0];
               pldf_pkg::CSR_ANCHOR_Z:     anchor_z = csr_wdata[COORD_WIDTH-1:0];
               pldf_pkg::CSR_DIRECTION_X:  dir_x    = csr_wdata[pldf_pkg::DIR_WIDTH-1:0];
               pldf_pkg::CSR_DIRECTION_Y:  dir_y    = csr_wdata[pldf_pkg::DIR_WIDTH-1:0];
               pldf_pkg::CSR_DIRECTION_Z:  dir_z    = csr_wdata[pldf_pkg::DIR_WIDTH-1:0];
               pldf_pkg::CSR_MAX_DISTANCE: max_dist = csr_wdata[pldf_pkg::MAXD_WIDTH-1:0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               note_mismatch($sformatf("unexpected transfer (%0d, %0d, %0d, %0d)",
                                       rsp_is_close, rsp_out_x, rsp_out_y, rsp_out_z));
            end else begin
               oldest = pending_verdicts.pop_front();
               check_field("is_close", 32'(oldest.is_close), 32'(rsp_is_close));
               check_field("out_x", 32'(oldest.x), 32'(rsp_out_x));
               check_field("out_y", 32'(oldest.y), 32'(rsp_out_y));
               check_field("out_z", 32'(oldest.z), 32'(rsp_out_z));
            end
            results_seen++;
         end

         if (req_valid && !req_stall) begin
            incoming = '{point_near_line(req_point_x, req_point_y, req_point_z),
                         req_point_x, req_point_y, req_point_z};
            pending_verdicts = {pending_verdicts, incoming};
         end
      end
      points_in_flight = pending_verdicts.size();
   end

endmodule

// ===== tb/sv/point_line_distance_filter_tb.sv =====
// ----------------------------------------------------------------------------
// point_line_distance_filter_tb
// Stimulus and verdict for the point-to-line distance filter.
// A directed set covers extreme coordinates, extreme and non-unit directions,
// zero and full-scale limits and the equality boundary; then randomized line
// setups are each followed by a burst of points, most near the line. Both
// channels idle at random; one phase holds the result side off long enough
// to back the pipeline up. Checking is done by pldf_distance_checker.
// ----------------------------------------------------------------------------
module point_line_distance_filter_tb;

   localparam int COORD_W = pldf_pkg::DEFAULT_COORD_WIDTH;
   localparam int CSR_W   = (COORD_W > pldf_pkg::MAXD_WIDTH) ? COORD_W : pldf_pkg::MAXD_WIDTH;

   // decoded by nothing, writes to it must be dropped
   localparam logic [pldf_pkg::CSR_INDEX_WIDTH-1:0] CSR_INDEX_NONE = 3'd7;

   localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
   localparam longint COORD_MIN = -(longint'(1) <<< (COORD_W - 1));
   localparam longint MAXD_MAX  = (longint'(1) <<< pldf_pkg::MAXD_WIDTH) - 1;
   localparam longint ONE       = 4096;      // 1.0 in coordinate format

   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_POINTS  = 114;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 20;       // settle after the final drain, with margin
   // longest legal quiet stretch is the hold above; allow several times that
   localparam int IDLE_LIMIT    = 4000;

   logic                                  clock        = 1'b0;
   logic                                  reset        = 1'b1;
   logic                                  req_valid    = 1'b0;
   logic                                  req_stall;
   logic signed [COORD_W-1:0]             req_point_x  = '0;
   logic signed [COORD_W-1:0]             req_point_y  = '0;
   logic signed [COORD_W-1:0]             req_point_z  = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall    = 1'b0;
   logic                                  rsp_is_close;
   logic signed [COORD_W-1:0]             rsp_out_x;
   logic signed [COORD_W-1:0]             rsp_out_y;
   logic signed [COORD_W-1:0]             rsp_out_z;
   logic                                  csr_write    = 1'b0;
   logic [pldf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index    = '0;
   logic [CSR_W-1:0]                      csr_wdata    = '0;

   int mismatch_count;
   int points_in_flight;

   // line as last written, used only to aim points near it
   longint line_anchor [3];
   longint line_dir [3];
   longint line_maxd;

   logic sender_idle_on = 1'b0;
   logic rsp_idle_on    = 1'b0;
   int   holds_requested = 0;
   int   holds_served    = 0;
   int   hold_left       = 0;
   int   run_left        = 0;
   logic run_level       = 1'b0;
   int   idle_cycles     = 0;

   always #4 clock = ~clock;

   point_line_distance_filter #(
      .COORD_WIDTH (COORD_W)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_point_z  (req_point_z),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_close (rsp_is_close),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   pldf_distance_checker #(
      .COORD_WIDTH (COORD_W),
      .CSR_WIDTH   (CSR_W)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_close     (rsp_is_close),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .points_in_flight (points_in_flight)
   );

   // result side: a requested long hold wins, else random runs if rsp_idle_on
   always @(negedge clock) begin
      if (holds_served != holds_requested) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!rsp_idle_on) begin
         rsp_stall <= 1'b0;
      end else begin
         if (run_left == 0) begin
            run_level = ($urandom_range(0, 3) == 0);
            run_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 4);
         end
         run_left--;
         rsp_stall <= run_level;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic send_point(input longint x, input longint y, input longint z);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_point_x <= COORD_W'(x);
      req_point_y <= COORD_W'(y);
      req_point_z <= COORD_W'(z);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (points_in_flight == 0);
   endtask

   function automatic int sender_gap();
      int r;
      if (!sender_idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(15, 50);
   endfunction

   task automatic write_reg(input logic [pldf_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // register value in its low bits, random junk above them
   function automatic logic [CSR_W-1:0] with_junk(input longint val, input int width);
      logic [CSR_W-1:0] mask;
      logic [CSR_W-1:0] junk;
      mask = CSR_W'((longint'(1) << width) - 1);
      junk = CSR_W'($urandom);
      return (junk & ~mask) | (CSR_W'(val) & mask);
   endfunction

   task automatic configure_line(input longint ax, input longint ay, input longint az,
                                 input longint dx, input longint dy, input longint dz,
                                 input longint maxd);
      line_anchor[0] = ax;
      line_anchor[1] = ay;
      line_anchor[2] = az;
      line_dir[0]    = dx;
      line_dir[1]    = dy;
      line_dir[2]    = dz;
      line_maxd      = maxd;
      write_reg(pldf_pkg::CSR_ANCHOR_X, CSR_W'(ax));
      write_reg(pldf_pkg::CSR_ANCHOR_Y, CSR_W'(ay));
      write_reg(pldf_pkg::CSR_ANCHOR_Z, CSR_W'(az));
      write_reg(pldf_pkg::CSR_DIRECTION_X, with_junk(dx, pldf_pkg::DIR_WIDTH));
      write_reg(pldf_pkg::CSR_DIRECTION_Y, with_junk(dy, pldf_pkg::DIR_WIDTH));
      write_reg(pldf_pkg::CSR_DIRECTION_Z, with_junk(dz, pldf_pkg::DIR_WIDTH));
      write_reg(pldf_pkg::CSR_MAX_DISTANCE, with_junk(maxd, pldf_pkg::MAXD_WIDTH));
      write_reg(CSR_INDEX_NONE, CSR_W'($urandom));
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic longint corner_coord();
      case ($urandom_range(0, 5))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return 0;
         3:       return -1;
         4:       return 1;
         default: return longint'($urandom_range(0, 2 * ONE)) - ONE;
      endcase
   endfunction

   function automatic longint full_coord();
      return longint'($urandom_range(0, 32'(2 * COORD_MAX + 1))) + COORD_MIN;
   endfunction

   task automatic random_line();
      longint a [3];
      longint d [3];
      longint maxd;
      real    c [3];
      real    norm;
      int     sel;
      for (int i = 0; i < 3; i++) begin
         sel = $urandom_range(0, 9);
         if (sel < 5)
            a[i] = longint'($urandom_range(0, 1 << 17)) - (1 << 16);
         else if (sel < 8)
            a[i] = full_coord();
         else
            a[i] = corner_coord();
      end
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
         d[0] = 0;
         d[1] = 0;
         d[2] = 0;
         d[$urandom_range(0, 2)] = ($urandom_range(0, 1) == 1) ? 16384 : -16384;
      end else if (sel < 8) begin
         for (int i = 0; i < 3; i++)
            c[i] = real'($urandom_range(0, 32768)) - 16384.0;
         norm = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]);
         if (norm < 1.0) begin
            c[0] = 1.0;
            norm = 1.0;
         end
         for (int i = 0; i < 3; i++)
            d[i] = $rtoi(c[i] / norm * 16384.0);
      end else begin
         // raw 16-bit values over the whole +-2.0 range, not unit length
         for (int i = 0; i < 3; i++)
            d[i] = longint'($urandom_range(0, 65535)) - 32768;
      end
      case ($urandom_range(0, 5))
         0:       maxd = 0;
         1:       maxd = $urandom_range(1, 255);
         2:       maxd = $urandom_range(256, 65535);
         3:       maxd = $urandom_range(0, 32'(MAXD_MAX));
         4:       maxd = MAXD_MAX;
         default: maxd = $urandom_range(32'(ONE), 1 << 20);
      endcase
      configure_line(a[0], a[1], a[2], d[0], d[1], d[2], maxd);
   endtask

   // mostly points scattered around the line within about max_distance
   task automatic make_point(output longint x, output longint y, output longint z);
      longint p [3];
      longint t, m;
      int     pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         t = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
         m = line_maxd + 2;
         for (int i = 0; i < 3; i++)
            p[i] = line_anchor[i] + ((t * line_dir[i]) >>> pldf_pkg::DIR_FRAC)
                   + longint'($urandom_range(0, 32'(2 * m))) - m;
      end else if (pick < 85) begin
         for (int i = 0; i < 3; i++)
            p[i] = full_coord();
      end else begin
         for (int i = 0; i < 3; i++)
            p[i] = corner_coord();
      end
      x = p[0];
      y = p[1];
      z = p[2];
   endtask

   initial begin
      longint x, y, z;

      line_anchor = '{0, 0, 0};
      line_dir    = '{16384, 0, 0};
      line_maxd   = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // reset line: x axis through the origin, zero limit
      send_point(0, 0, 0);
      send_point(COORD_MAX, 0, 0);
      send_point(COORD_MIN, 0, 0);
      send_point(0, 1, 0);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      send_point(COORD_MIN, COORD_MAX, -1);
      drain();

      configure_line(COORD_MIN, COORD_MAX, 0, 0, -16384, 0, MAXD_MAX);
      send_point(COORD_MAX, COORD_MIN, COORD_MAX);
      send_point(COORD_MIN, COORD_MAX, 0);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(0, 0, 0);
      drain();

      // direction far from unit length, two components at the 16-bit extremes
      configure_line(COORD_MAX, COORD_MIN, COORD_MAX, 32767, -32768, 12345, ONE);
      send_point(COORD_MAX, COORD_MIN, COORD_MAX);
      send_point(COORD_MIN, COORD_MAX, COORD_MIN);
      send_point(COORD_MAX, COORD_MAX, COORD_MIN);
      send_point(1, -1, 0);
      drain();

      configure_line(0, 0, 0, 9459, 9459, 9459, ONE);
      send_point(ONE, ONE, ONE);
      send_point(0, ONE, 0);
      send_point(0, 2 * ONE, 0);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      send_point(-ONE, -ONE, -ONE);
      drain();

      // residual exactly at the limit counts as close
      configure_line(0, 0, 0, 16384, 0, 0, ONE);
      send_point(5, ONE, 0);
      send_point(5, ONE + 1, 0);
      send_point(0, 0, -ONE);
      send_point(7, 2458, 3277);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain();
         random_line();
         sender_idle_on = (ph != 0) && (ph != 2) && ($urandom_range(0, 3) != 0);
         rsp_idle_on    = (ph != 0) && (ph != 2) && ($urandom_range(0, 3) != 0);
         if (ph == 2)
            holds_requested++;
         for (int n = 0; n < PHASE_POINTS; n++) begin
            if (ph == 4 && n == PHASE_POINTS / 2)
               drain();
            idle_sender(sender_gap());
            make_point(x, y, z);
            send_point(x, y, z);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && points_in_flight == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
